### rtl/alst_pkg.sv
// Shared types and codes for the array list block.
package alst_pkg;

  // Field widths of the two channels
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 5;
  localparam int OUT_DATA_W = 8;

  // Command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  // One finished result, sequencer to output stage
  typedef struct packed {
    logic                 is_empty;
    logic [OUT_CNT_W-1:0] count;
    logic [STATUS_W-1:0]  status;
  } res_t;

endpackage

### rtl/alst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/alst_ctrl.sv
// Command sequencer: append, scan for a match and shift the tail down.
module alst_ctrl #(
  parameter int CAPACITY = 16,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic                   cmd,
  input  logic [alst_pkg::VALUE_W-1:0] value,
  output logic                   res_valid,
  input  logic                   res_ready,
  output alst_pkg::res_t         res,
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output logic [alst_pkg::VALUE_W-1:0] mem_wr_data,
  output logic [AW-1:0]          mem_rd_addr,
  input  logic [alst_pkg::VALUE_W-1:0] mem_rd_data
);
  import alst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic                pend_r, pend_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic                match;
  logic                more;
  logic [CW+OUT_CNT_W-1:0] cnt_wide;

  // Compare the entry read last cycle; check for entries left to read
  assign match = pend_r && (mem_rd_data == val_r);
  assign more  = (idx_r < cnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd == CMD_APPEND || cnt_r == '0) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_nxt = ST_SHIFT;
        end else if (!more) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_SHIFT: begin
        if (!more) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory accesses
  always_comb begin
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    wa_nxt      = wa_r;
    pend_nxt    = pend_r;
    val_nxt     = val_r;
    st_nxt      = st_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wa_r;
    mem_wr_data = mem_rd_data;
    mem_rd_addr = idx_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          val_nxt  = value;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          if (cmd == CMD_APPEND) begin
            if (cnt_r == CW'(CAPACITY)) begin
              st_nxt = STAT_FULL;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = cnt_r[AW-1:0];
              mem_wr_data = value;
              cnt_nxt     = cnt_r + CW'(1);
              st_nxt      = STAT_DONE;
            end
          end else if (cnt_r == '0) begin
            st_nxt = STAT_EMPTY;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          // Match sits at idx_r - 1; the shift starts reading at idx_r
          pend_nxt = 1'b0;
        end else if (!more) begin
          st_nxt   = STAT_MISSING;
          pend_nxt = 1'b0;
        end else begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      ST_SHIFT: begin
        // Write the entry read last cycle one place lower
        if (pend_r) begin
          mem_wr_en = 1'b1;
        end
        if (more) begin
          wa_nxt   = AW'(idx_r - CW'(1));
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          cnt_nxt  = cnt_r - CW'(1);
          st_nxt   = STAT_DONE;
          pend_nxt = 1'b0;
        end
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Handshake and result fields
  assign cmd_ready     = (state_r == ST_IDLE);
  assign res_valid     = (state_r == ST_RESULT);
  assign cnt_wide      = {{OUT_CNT_W{1'b0}}, cnt_r};
  assign res.status    = st_r;
  assign res.count     = cnt_wide[OUT_CNT_W-1:0];
  assign res.is_empty  = (cnt_r == '0);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    wa_r  <= wa_nxt;
    val_r <= val_nxt;
    st_r  <= st_nxt;
  end

endmodule

### rtl/array_list_append_remove.sv
// Array list top level: append and remove on a packed list held in one RAM.
// Append, and remove on an empty list, go straight to the result; any other remove first scans
// for a match, then shifts the tail down. The result is held in a registered output stage.
// One command at a time: in_tready returns once the result enters the output register,
// so a new command is taken only after the last result is loaded; a low out_tready holds it off.
// Reset clears the count, the sequencer and the output valid; RAM contents are kept.
module array_list_append_remove #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [6:2] count, [7] is_empty
);
  import alst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [VALUE_W-1:0] mem_wr_data;
  logic [AW-1:0]      mem_rd_addr;
  logic [VALUE_W-1:0] mem_rd_data;
  logic               out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  alst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .cmd         (in_tuser),
    .value       (in_tdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  alst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Load the output register when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### rtl/alst_chk.sv
// Port-level checks for the array list block, bound to the top level.
module alst_chk #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);
  import alst_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Empty flag follows the count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7] == (out_tdata[6:2] == 5'd0)))
    else $error("empty flag disagrees with count");

  // A full report carries the capacity as count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == STAT_FULL |-> out_tdata[6:2] == OUT_CNT_W'(CAPACITY))
    else $error("full reported below capacity");

  // An empty report carries a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == STAT_EMPTY |-> out_tdata[6:2] == 5'd0)
    else $error("empty reported with entries held");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind array_list_append_remove alst_chk #(.CAPACITY(CAPACITY)) u_alst_chk (.*);
